FILE: design/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg
// Shared widths, register indexes and constants for the absorbing-surface
// Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package fra_pkg;

  localparam int CosW    = 16;   // cosine, Q1.15
  localparam int ReflW   = 17;   // reflectivity, Q1.16
  localparam int RegW    = 16;   // n, k, Q6.10
  localparam int CfgIdxW = 8;
  localparam int DataW   = 24;   // output tdata, byte padded

  localparam int S2W  = 30;      // sin^2, Q30
  localparam int XW   = 29;      // |x|, Q16
  localparam int PW   = 29;      // 2nk, Q16
  localparam int RadW = 60;      // x^2 + (2nk)^2
  localparam int RW   = 30;      // r
  localparam int A2W  = 30;      // a^2, b^2
  localparam int AW   = 23;      // a
  localparam int TW   = 31;      // t = sin^2 / cos
  localparam int SumW = 32;      // a + u
  localparam int LenW = 23;      // scaled lengths
  localparam int MaxShift = SumW - LenW;
  localparam int SqW  = 46;      // squares of scaled lengths
  localparam int FracW = 47;     // ratio numerator and denominator

  localparam logic [CfgIdxW-1:0] RegIndexReal = 8'd0;
  localparam logic [CfgIdxW-1:0] RegIndexImag = 8'd1;

  localparam logic [RegW-1:0]  IndexRealReset = 16'd1024;
  localparam logic [RegW-1:0]  IndexImagReset = 16'd0;
  localparam logic [CosW-1:0]  CosOne  = 16'd32768;
  localparam logic [ReflW-1:0] ReflOne = 17'h10000;

endpackage

FILE: design/fra_isqrt.sv
// ----------------------------------------------------------------------------
// fra_isqrt
// Pipelined integer square root, one result bit per stage, with a sideband
// that travels alongside.
// ----------------------------------------------------------------------------
module fra_isqrt #(
  parameter int RootW = 30,
  parameter int SideW = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [2*RootW-1:0] in_rad,
  input  logic [SideW-1:0]   in_side,
  output logic               out_valid,
  output logic [RootW-1:0]   out_root,
  output logic [SideW-1:0]   out_side
);

  localparam int RadW = 2 * RootW;
  localparam int RemW = RootW + 2;

  logic             vld  [RootW];
  logic [RadW-1:0]  rad  [RootW];
  logic [RemW-1:0]  rem  [RootW];
  logic [RootW-1:0] root [RootW];
  logic [SideW-1:0] side [RootW];

  for (genvar g = 0; g < RootW; g++) begin : g_step
    logic             pv;
    logic [RadW-1:0]  prad;
    logic [RemW-1:0]  prem;
    logic [RootW-1:0] proot;
    logic [SideW-1:0] pside;
    logic [RemW-1:0]  shifted;
    logic [RemW-1:0]  trial;
    logic             ge;

    if (g == 0) begin : g_first
      assign pv    = in_valid;
      assign prad  = in_rad;
      assign prem  = '0;
      assign proot = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld[g-1];
      assign prad  = rad[g-1];
      assign prem  = rem[g-1];
      assign proot = root[g-1];
      assign pside = side[g-1];
    end

    assign shifted = {prem[RemW-3:0], prad[RadW-1 -: 2]};
    assign trial   = {proot, 2'b01};
    assign ge      = shifted >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[g]  <= prad << 2;
        rem[g]  <= ge ? shifted - trial : shifted;
        root[g] <= {proot[RootW-2:0], ge};
        side[g] <= pside;
      end
    end
  end

  assign out_valid = vld[RootW-1];
  assign out_root  = root[RootW-1];
  assign out_side  = side[RootW-1];

endmodule

FILE: design/fra_div.sv
// ----------------------------------------------------------------------------
// fra_div
// Pipelined restoring divider, one quotient bit per stage. The caller hands
// in the upper part of the dividend already reduced below the divisor.
// ----------------------------------------------------------------------------
module fra_div #(
  parameter int DenW  = 16,
  parameter int QW    = 17,
  parameter int SideW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DenW-1:0]  in_rem,
  input  logic [QW-1:0]    in_lo,
  input  logic [DenW-1:0]  in_den,
  input  logic [SideW-1:0] in_side,
  output logic             out_valid,
  output logic [QW-1:0]    out_quo,
  output logic [SideW-1:0] out_side
);

  logic             vld  [QW];
  logic [DenW-1:0]  rem  [QW];
  logic [QW-1:0]    lo   [QW];
  logic [QW-1:0]    quo  [QW];
  logic [DenW-1:0]  den  [QW];
  logic [SideW-1:0] side [QW];

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic             pv;
    logic [DenW-1:0]  prem;
    logic [QW-1:0]    plo;
    logic [QW-1:0]    pquo;
    logic [DenW-1:0]  pden;
    logic [SideW-1:0] pside;
    logic [DenW:0]    shifted;
    logic [DenW:0]    diff;
    logic             ge;

    if (g == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = in_rem;
      assign plo   = in_lo;
      assign pquo  = '0;
      assign pden  = in_den;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld[g-1];
      assign prem  = rem[g-1];
      assign plo   = lo[g-1];
      assign pquo  = quo[g-1];
      assign pden  = den[g-1];
      assign pside = side[g-1];
    end

    assign shifted = {prem, plo[QW-1]};
    assign diff    = shifted - {1'b0, pden};
    assign ge      = shifted >= {1'b0, pden};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g]  <= ge ? diff[DenW-1:0] : shifted[DenW-1:0];
        lo[g]   <= plo << 1;
        quo[g]  <= {pquo[QW-2:0], ge};
        den[g]  <= pden;
        side[g] <= pside;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quo   = quo[QW-1];
  assign out_side  = side[QW-1];

endmodule

FILE: design/fresnel_reflectance_absorbing.sv
// ----------------------------------------------------------------------------
// fresnel_reflectance_absorbing
// Unpolarized Fresnel reflectance of an absorbing surface, n + ik from config.
// ----------------------------------------------------------------------------
// Takes one cosine beat per cycle while s_tready is high and returns one
// reflectivity beat per input, in order. The pipeline holds the bit-serial
// stages of the t = sin^2/cos divider (31), the two square roots (30 and 23)
// and the ratio dividers (17). The whole pipeline advances together, so
// s_tready falls only while a finished beat waits at the output. A cosine of
// zero gives 1.0 with the grazing flag in m_tuser. Write n and k only while
// no beat is in flight.
module fresnel_reflectance_absorbing
  import fra_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [CosW-1:0]    s_tdata,   // [15:0] cos_incidence
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [DataW-1:0]   m_tdata,   // [16:0] reflectivity
  output logic [0:0]         m_tuser,   // [0] grazing
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [RegW-1:0]    cfg_data
);

  localparam int TdSideW = 1 + CosW + 1 + XW + PW;
  localparam int RsSideW = 1 + CosW + 1 + XW + TW;
  localparam int AsSideW = 1 + CosW + TW + A2W;

  logic [RegW-1:0] index_real;
  logic [RegW-1:0] index_imag;
  logic            en;

  assign cfg_ready = 1'b1;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_real <= IndexRealReset;
      index_imag <= IndexImagReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegIndexReal: index_real <= cfg_data;
        RegIndexImag: index_imag <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage A: clamp, products
  logic            a_valid;
  logic            a_graz;
  logic [CosW-1:0] a_cq;
  logic [30:0]     a_cq2;
  logic [31:0]     a_nsq;
  logic [31:0]     a_ksq;
  logic [31:0]     a_nk;
  logic [CosW-1:0] cos_clamp;

  assign cos_clamp = (s_tdata > CosOne) ? CosOne : s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_graz <= s_tdata == '0;
      a_cq   <= cos_clamp;
      a_cq2  <= 31'(cos_clamp) * 31'(cos_clamp);
      a_nsq  <= 32'(index_real) * 32'(index_real);
      a_ksq  <= 32'(index_imag) * 32'(index_imag);
      a_nk   <= 32'(index_real) * 32'(index_imag);
    end
  end

  // stage B: sin^2, x as sign and magnitude, 2nk
  logic            b_valid;
  logic            b_graz;
  logic [CosW-1:0] b_cq;
  logic [S2W-1:0]  b_s2;
  logic [XW-1:0]   b_xmag;
  logic            b_xneg;
  logic [PW-1:0]   b_pq;
  logic [S2W-1:0]  s2_c;
  logic [32:0]     sub_c;
  logic [32:0]     nsq_c;
  logic            xneg_c;
  logic [32:0]     xdiff_c;

  assign s2_c    = S2W'((31'd1 << 30) - a_cq2);
  assign sub_c   = 33'(a_ksq) + 33'(s2_c >> 10);
  assign nsq_c   = 33'(a_nsq);
  assign xneg_c  = nsq_c < sub_c;
  assign xdiff_c = xneg_c ? sub_c - nsq_c : nsq_c - sub_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_graz <= a_graz;
      b_cq   <= a_cq;
      b_s2   <= s2_c;
      b_xmag <= xdiff_c[32:4];
      b_xneg <= xneg_c;
      b_pq   <= a_nk[31:3];
    end
  end

  // t = (sin^2 << 1) / cos
  logic               td_valid;
  logic [TW-1:0]      td_quo;
  logic [TdSideW-1:0] td_side;
  logic               td_graz;
  logic [CosW-1:0]    td_cq;
  logic               td_xneg;
  logic [XW-1:0]      td_xmag;
  logic [PW-1:0]      td_pq;

  fra_div #(
    .DenW  (CosW),
    .QW    (TW),
    .SideW (TdSideW)
  ) u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .in_rem    ('0),
    .in_lo     ({b_s2, 1'b0}),
    .in_den    (b_cq),
    .in_side   ({b_graz, b_cq, b_xneg, b_xmag, b_pq}),
    .out_valid (td_valid),
    .out_quo   (td_quo),
    .out_side  (td_side)
  );

  assign {td_graz, td_cq, td_xneg, td_xmag, td_pq} = td_side;

  // stage C: squares
  logic            c_valid;
  logic            c_graz;
  logic [CosW-1:0] c_cq;
  logic            c_xneg;
  logic [XW-1:0]   c_xmag;
  logic [TW-1:0]   c_t16;
  logic [57:0]     c_xsq;
  logic [57:0]     c_psq;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= td_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_graz <= td_graz;
      c_cq   <= td_cq;
      c_xneg <= td_xneg;
      c_xmag <= td_xmag;
      c_t16  <= td_quo;
      c_xsq  <= 58'(td_xmag) * 58'(td_xmag);
      c_psq  <= 58'(td_pq) * 58'(td_pq);
    end
  end

  // stage D: radicand
  logic            d_valid;
  logic            d_graz;
  logic [CosW-1:0] d_cq;
  logic            d_xneg;
  logic [XW-1:0]   d_xmag;
  logic [TW-1:0]   d_t16;
  logic [RadW-1:0] d_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_graz <= c_graz;
      d_cq   <= c_cq;
      d_xneg <= c_xneg;
      d_xmag <= c_xmag;
      d_t16  <= c_t16;
      d_rad  <= RadW'(c_xsq) + RadW'(c_psq);
    end
  end

  // r = sqrt(x^2 + (2nk)^2)
  logic               rs_valid;
  logic [RW-1:0]      rs_root;
  logic [RsSideW-1:0] rs_side;
  logic               rs_graz;
  logic [CosW-1:0]    rs_cq;
  logic               rs_xneg;
  logic [XW-1:0]      rs_xmag;
  logic [TW-1:0]      rs_t16;

  fra_isqrt #(
    .RootW (RW),
    .SideW (RsSideW)
  ) u_rsqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .in_rad    (d_rad),
    .in_side   ({d_graz, d_cq, d_xneg, d_xmag, d_t16}),
    .out_valid (rs_valid),
    .out_root  (rs_root),
    .out_side  (rs_side)
  );

  assign {rs_graz, rs_cq, rs_xneg, rs_xmag, rs_t16} = rs_side;

  // stage E: a^2, b^2
  logic            e_valid;
  logic            e_graz;
  logic [CosW-1:0] e_cq;
  logic [TW-1:0]   e_t16;
  logic [A2W-1:0]  e_a2;
  logic [A2W-1:0]  e_b2;
  logic [RW:0]     rpx_c;
  logic [RW:0]     rmx_c;

  assign rpx_c = (RW + 1)'(rs_root) + (RW + 1)'(rs_xmag);
  assign rmx_c = (RW + 1)'(rs_root) - (RW + 1)'(rs_xmag);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= rs_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_graz <= rs_graz;
      e_cq   <= rs_cq;
      e_t16  <= rs_t16;
      e_a2   <= rs_xneg ? rmx_c[RW:1] : rpx_c[RW:1];
      e_b2   <= rs_xneg ? rpx_c[RW:1] : rmx_c[RW:1];
    end
  end

  // a = sqrt(a^2 << 16)
  logic               as_valid;
  logic [AW-1:0]      as_root;
  logic [AsSideW-1:0] as_side;
  logic               f_graz;
  logic [CosW-1:0]    f_cq;
  logic [TW-1:0]      f_t16;
  logic [A2W-1:0]     f_b2;

  fra_isqrt #(
    .RootW (AW),
    .SideW (AsSideW)
  ) u_asqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .in_rad    ({e_a2, 16'd0}),
    .in_side   ({e_graz, e_cq, e_t16, e_b2}),
    .out_valid (as_valid),
    .out_root  (as_root),
    .out_side  (as_side)
  );

  assign {f_graz, f_cq, f_t16, f_b2} = as_side;

  // ratio lanes: 0 uses c = cos << 1, 1 uses t
  logic            g_valid, h_valid, i_valid, j_valid, k_valid;
  logic            g_graz, h_graz, i_graz, j_graz, k_graz;
  logic [AW-1:0]   g_a;
  logic [A2W-1:0]  g_b2;
  logic [SumW-1:0] lane_u [2];
  logic [SumW-1:0] g_u    [2];
  logic [SumW-1:0] g_sum  [2];
  logic [LenW-1:0] h_as   [2];
  logic [LenW-1:0] h_us   [2];
  logic [A2W-1:0]  h_bs   [2];
  logic [LenW-1:0] i_d    [2];
  logic [LenW-1:0] i_sp   [2];
  logic [A2W-1:0]  i_bs   [2];
  logic [SqW-1:0]  j_d2   [2];
  logic [SqW-1:0]  j_sp2  [2];
  logic [A2W-1:0]  j_bs   [2];
  logic [FracW-1:0] k_num [2];
  logic [FracW-1:0] k_den [2];

  assign lane_u[0] = SumW'({f_cq, 1'b0});
  assign lane_u[1] = SumW'(f_t16);

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
      h_valid <= 1'b0;
      i_valid <= 1'b0;
      j_valid <= 1'b0;
      k_valid <= 1'b0;
    end else if (en) begin
      g_valid <= as_valid;
      h_valid <= g_valid;
      i_valid <= h_valid;
      j_valid <= i_valid;
      k_valid <= j_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_graz <= f_graz;
      h_graz <= g_graz;
      i_graz <= h_graz;
      j_graz <= i_graz;
      k_graz <= j_graz;
      g_a    <= as_root;
      g_b2   <= f_b2;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [3:0]      sh;
    logic [LenW-1:0] lo_len;
    logic [LenW-1:0] hi_len;

    always_comb begin
      sh = '0;
      for (int i = 0; i < MaxShift; i++) begin
        if (g_sum[l][LenW+i]) begin
          sh = 4'(i + 1);
        end
      end
    end

    assign lo_len = (h_as[l] >= h_us[l]) ? h_us[l] : h_as[l];
    assign hi_len = (h_as[l] >= h_us[l]) ? h_as[l] : h_us[l];

    always_ff @(posedge clk) begin
      if (en) begin
        g_u[l]   <= lane_u[l];
        g_sum[l] <= SumW'(as_root) + lane_u[l];
        h_as[l]  <= LenW'(SumW'(g_a) >> sh);
        h_us[l]  <= LenW'(g_u[l] >> sh);
        h_bs[l]  <= g_b2 >> {sh, 1'b0};
        i_d[l]   <= hi_len - lo_len;
        i_sp[l]  <= h_as[l] + h_us[l];
        i_bs[l]  <= h_bs[l];
        j_d2[l]  <= SqW'(i_d[l]) * SqW'(i_d[l]);
        j_sp2[l] <= SqW'(i_sp[l]) * SqW'(i_sp[l]);
        j_bs[l]  <= i_bs[l];
        k_num[l] <= FracW'(j_d2[l]) + FracW'({j_bs[l], 16'd0});
        k_den[l] <= FracW'(j_sp2[l]) + FracW'({j_bs[l], 16'd0});
      end
    end
  end

  logic             q0_valid;
  logic [ReflW-1:0] q0_quo;
  logic [1:0]       q0_side;
  logic             q1_valid;
  logic [ReflW-1:0] q1_quo;
  logic             q1_side;
  logic             zden0;
  logic             zden1;

  assign zden0 = k_den[0] == '0;
  assign zden1 = k_den[1] == '0;

  fra_div #(
    .DenW  (FracW),
    .QW    (ReflW),
    .SideW (2)
  ) u_rdiv0 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (k_valid),
    .in_rem    ({1'b0, k_num[0][FracW-1:1]}),
    .in_lo     ({k_num[0][0], 16'd0}),
    .in_den    (k_den[0]),
    .in_side   ({zden0, k_graz}),
    .out_valid (q0_valid),
    .out_quo   (q0_quo),
    .out_side  (q0_side)
  );

  fra_div #(
    .DenW  (FracW),
    .QW    (ReflW),
    .SideW (1)
  ) u_rdiv1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (k_valid),
    .in_rem    ({1'b0, k_num[1][FracW-1:1]}),
    .in_lo     ({k_num[1][0], 16'd0}),
    .in_den    (k_den[1]),
    .in_side   (zden1),
    .out_valid (q1_valid),
    .out_quo   (q1_quo),
    .out_side  (q1_side)
  );

  // stage L: Rs and Rp
  logic             l_valid;
  logic             l_graz;
  logic [ReflW-1:0] l_rs;
  logic [ReflW-1:0] l_rp;
  logic [ReflW-1:0] ratio0;
  logic [ReflW-1:0] ratio1;
  logic [33:0]      rp_full;

  assign ratio0  = q0_side[1] ? ReflOne : q0_quo;
  assign ratio1  = q1_side ? ReflOne : q1_quo;
  assign rp_full = 34'(ratio0) * 34'(ratio1);

  always_ff @(posedge clk) begin
    if (rst) begin
      l_valid <= 1'b0;
    end else if (en) begin
      l_valid <= q0_valid && q1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_graz <= q0_side[0];
      l_rs   <= ratio0;
      l_rp   <= rp_full[ReflW+15:16];
    end
  end

  // output register
  logic [ReflW:0]   sum_c;
  logic [ReflW-1:0] refl_c;

  assign sum_c  = (ReflW + 1)'(l_rs) + (ReflW + 1)'(l_rp);
  assign refl_c = (l_graz || sum_c[ReflW:1] > ReflOne) ? ReflOne : sum_c[ReflW:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= l_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= DataW'(refl_c);
      m_tuser <= l_graz;
    end
  end

`ifndef SYNTH
  a_graz_one: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[ReflW-1:0] == ReflOne)
    else $error("grazing beat without full reflectivity");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[ReflW-1:0] <= ReflOne && m_tdata[DataW-1:ReflW] == '0)
    else $error("reflectivity above 1.0");

  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output beat held");

  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(l_rs) && $stable(l_rp) && $stable(l_valid))
    else $error("pipeline moved during stall");
`endif

endmodule

FILE: verif/fra_checker.sv
// ----------------------------------------------------------------------------
// fra_checker
// Watches the config, cosine and reflectivity channels of the Fresnel block,
// computes the expected reflectivity and grazing flag for every accepted
// cosine beat and compares them in order against the output beats.
// ----------------------------------------------------------------------------
module fra_checker
  import fra_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [CosW-1:0]    s_tdata,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [DataW-1:0]   m_tdata,
  input  logic [0:0]         m_tuser,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [RegW-1:0]    cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [ReflW-1:0] refl;
    logic             grazing;
  } refl_beat_t;

  refl_beat_t     refl_q[$];
  logic [63:0]    n_reg, k_reg;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] refl_ratio(logic [63:0] a, logic [63:0] u,
                                              logic [63:0] b2);
    int unsigned sh;
    logic [63:0] as, us, bs, d, num, den;
    sh = 0;
    while (sh < 31 && ((((a + u) >> sh) >= (64'd1 << 23)) ||
                       ((b2 >> (2 * sh)) >= (64'd1 << 30))))
      sh++;
    as = a >> sh;
    us = u >> sh;
    bs = (b2 >> (2 * sh)) << 16;
    d = (as >= us) ? as - us : us - as;
    num = d * d + bs;
    den = (as + us) * (as + us) + bs;
    if (den == 0) return 64'd65536;
    return (num << 16) / den;
  endfunction

  function automatic refl_beat_t predict_refl(logic [CosW-1:0] cos_in);
    refl_beat_t rb;
    logic [63:0] cq, s2, nsq, ksq, sub, xmag, pq, r, a2, b2, a, c16, t16;
    logic [63:0] rs, rp, rf;
    logic        xneg;
    cq = 64'(cos_in);
    if (cq == 0) begin
      rb.refl = ReflOne;
      rb.grazing = 1'b1;
      return rb;
    end
    if (cq > 64'(CosOne)) cq = 64'(CosOne);
    s2 = (64'd1 << 30) - cq * cq;
    nsq = n_reg * n_reg;
    ksq = k_reg * k_reg;
    sub = ksq + (s2 >> 10);
    xneg = nsq < sub;
    xmag = xneg ? sub - nsq : nsq - sub;
    xmag = xmag >> 4;
    pq = (n_reg * k_reg) >> 3;
    r = int_sqrt(xmag * xmag + pq * pq);
    if (xneg) begin
      a2 = (r - xmag) >> 1;
      b2 = (r + xmag) >> 1;
    end else begin
      a2 = (r + xmag) >> 1;
      b2 = (r - xmag) >> 1;
    end
    a = int_sqrt(a2 << 16);
    c16 = cq << 1;
    t16 = (s2 << 1) / cq;
    rs = refl_ratio(a, c16, b2);
    rp = (rs * refl_ratio(a, t16, b2)) >> 16;
    rf = (rs + rp) >> 1;
    if (rf > 64'd65536) rf = 64'd65536;
    rb.refl = rf[ReflW-1:0];
    rb.grazing = 1'b0;
    return rb;
  endfunction

  assign pending = refl_q.size();

  always @(posedge clk) begin
    refl_beat_t exp_b;
    if (rst) begin
      n_reg <= 64'(IndexRealReset);
      k_reg <= 64'(IndexImagReset);
      errors <= 0;
      refl_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegIndexReal) n_reg <= 64'(cfg_data);
        else if (cfg_index == RegIndexImag) k_reg <= 64'(cfg_data);
      end
      if (s_tvalid && s_tready) refl_q.push_back(predict_refl(s_tdata));
      if (m_tvalid && m_tready) begin
        if (refl_q.size() == 0) begin
          $display("%0t: unexpected beat refl=%0d grazing=%0d", $time,
                   m_tdata[ReflW-1:0], m_tuser[0]);
          errors <= errors + 1;
        end else begin
          exp_b = refl_q.pop_front();
          if (m_tdata[ReflW-1:0] !== exp_b.refl || m_tuser[0] !== exp_b.grazing ||
              m_tdata[DataW-1:ReflW] !== '0) begin
            $display("%0t: mismatch expected refl=%0d grazing=%0d actual refl=%0d grazing=%0d",
                     $time, exp_b.refl, exp_b.grazing, m_tdata[ReflW-1:0], m_tuser[0]);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

FILE: verif/tb_fresnel_reflectance_absorbing.sv
// ----------------------------------------------------------------------------
// tb_fresnel_reflectance_absorbing
// Drives cosine beats and n/k register writes through several index settings
// with random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_fresnel_reflectance_absorbing;
  import fra_pkg::*;

  localparam int Latency = 113;
  localparam int WatchLimit = 20000;

  logic               clk, rst;
  logic               s_tvalid, s_tready;
  logic [CosW-1:0]    s_tdata;
  logic               m_tvalid, m_tready;
  logic [DataW-1:0]   m_tdata;
  logic [0:0]         m_tuser;
  logic               cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [RegW-1:0]    cfg_data;
  int                 errors, pending;
  int                 idle_cycles;
  bit                 hold_out;

  fresnel_reflectance_absorbing u_dut (.*);

  fra_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_cos(logic [CosW-1:0] c, bit gaps);
    int g;
    g = gaps ? rand_gap() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  function automatic logic [CosW-1:0] rand_cos();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 16'd0;
    if (sel == 1) return 16'($urandom_range(32769, 65535));
    if (sel == 2) return CosOne;
    if (sel == 3) return 16'($urandom_range(1, 16));
    return 16'($urandom_range(1, 32768));
  endfunction

  // output-side stalls, plus one long hold-off
  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_out) m_tready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) m_tready <= ($urandom_range(0, 9) == 0) ? 1'b1 : 1'b0;
      else m_tready <= 1'b1;
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [RegW-1:0] n_vals[6];
    logic [RegW-1:0] k_vals[6];
    logic [CosW-1:0] directed[12];
    hold_out = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    n_vals = '{16'd1024, 16'd0, 16'd65535, 16'd1536, 16'd300, 16'd2000};
    k_vals = '{16'd0, 16'd0, 16'd65535, 16'd3000, 16'd5000, 16'd1};
    directed = '{16'd0, 16'd1, 16'd2, 16'd32768, 16'd32767, 16'd32769, 16'd65535,
                 16'd16384, 16'd23170, 16'd100, 16'h5555, 16'hAAAA};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset values, directed cosines
    foreach (directed[i]) send_cos(directed[i], 0);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(RegIndexReal, n_vals[p]);
      write_reg(RegIndexImag, k_vals[p]);
      if (p == 2) write_reg(8'd7, 16'h1234);
      foreach (directed[i]) if (i < 4) send_cos(directed[i], 1);
      if (p == 3) begin
        hold_out = 1;
        for (int i = 0; i < 250; i++) send_cos(rand_cos(), 0);
      end else begin
        for (int i = 0; i < 150; i++) send_cos(rand_cos(), 1);
      end
      drain();
      if (p == 3) hold_out = 0;
    end

    // random n, k
    for (int p = 0; p < 2; p++) begin
      write_reg(RegIndexReal, 16'($urandom()));
      write_reg(RegIndexImag, 16'($urandom()));
      for (int i = 0; i < 60; i++) send_cos(rand_cos(), 1);
      drain();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // releases the long hold-off after a while, in its own process
  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) begin
        repeat (400) @(posedge clk);
        hold_out = 0;
        while (pending != 0) @(posedge clk);
      end
    end
  end

endmodule
